/* src/nfa_word_acceptance_unit_assert.svh */
// Assertion macros for the NFA word acceptance unit.
// Included by the top level; it needs no other file.
`ifndef NFA_WORD_ACCEPTANCE_UNIT_ASSERT_SVH
`define NFA_WORD_ACCEPTANCE_UNIT_ASSERT_SVH

// The condition must never be true on a clock edge outside reset.
`define NFA_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("nfa: forbidden condition seen");

// When the antecedent holds, the consequent must hold in the next cycle.
`define NFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nfa: expected follow-up missing");

`endif

/* src/nfa_wa_pkg.sv */
// Shared types and constants of the NFA word acceptance unit.
// Used by the core, the table memory and the top level; depends on nothing.
`default_nettype none

package nfa_wa_pkg;

   // Field widths fixed by the interface.
   localparam int OPCODE_W = 2;
   localparam int STATE_W  = 4;
   localparam int SYMBOL_W = 8;
   localparam int SET_W    = 16;
   localparam int CSR_IDX_W = 1;

   // Default sizes of the automaton.
   localparam int DEF_NUM_STATES  = 16;
   localparam int DEF_NUM_SYMBOLS = 256;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_ADD     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_BEGIN   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CONSUME = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_STATE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_MASK    = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // Control of the transition table memory.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

/* src/nfa_word_acceptance_unit.sv */
// Top level of the NFA word acceptance unit: sequencer plus transition table.
// Depends on nfa_wa_pkg, nfa_wa_core, nfa_wa_table and the assertion header.
//
// Usage:
// - Request channel (req_*): one item per transfer, opcode add transition,
//   begin word or consume symbol. A transfer happens when req_valid is high
//   and req_stall is low.
// - Response channel (rsp_*): exactly one result per item, in order, held in
//   an output register until the receiver drops rsp_stall.
// - Configuration channel (csr_*): always ready; write only while idle.
// - Sequence: begin word and the unused opcode go from the idle state to done;
//   add and consume first pass through the exec state, after one registered
//   read of the table row. The sequencer handles one item at a time and takes
//   no new item until the output register has been loaded.
// - A consume merges all active states combinationally from a single row that
//   holds every next-state mask for that symbol.
// - Reset: the table is cleared row by row, all NUM_SYMBOLS rows (256 by
//   default), with req_stall high; configuration writes are taken meanwhile.
// - A stalled receiver keeps the result; the next item may still transfer
//   and waits in the sequencer until the output register frees.
`default_nettype none

`include "nfa_word_acceptance_unit_assert.svh"

module nfa_word_acceptance_unit #(
   parameter int NUM_STATES  = nfa_wa_pkg::DEF_NUM_STATES,
   parameter int NUM_SYMBOLS = nfa_wa_pkg::DEF_NUM_SYMBOLS
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [nfa_wa_pkg::OPCODE_W-1:0]   req_opcode,
   input  wire [nfa_wa_pkg::STATE_W-1:0]    req_from_state,
   input  wire [nfa_wa_pkg::SYMBOL_W-1:0]   req_symbol,
   input  wire [nfa_wa_pkg::STATE_W-1:0]    req_to_state,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [nfa_wa_pkg::SET_W-1:0]     rsp_active_set,
   output logic                             rsp_accepted,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [nfa_wa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [nfa_wa_pkg::SET_W-1:0]      csr_wdata
);

   localparam int SAW  = $clog2(NUM_SYMBOLS);
   localparam int ROWW = NUM_STATES * NUM_STATES;

   nfa_wa_pkg::mem_ctl_type mem_ctl;
   logic [SAW-1:0]          mem_rd_addr;
   logic [SAW-1:0]          mem_wr_addr;
   logic [ROWW-1:0]         mem_wr_data;
   logic [ROWW-1:0]         mem_rd_data;

   // Sequencer.
   nfa_wa_core #(
      .NUM_STATES  (NUM_STATES),
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_from_state (req_from_state),
      .req_symbol     (req_symbol),
      .req_to_state   (req_to_state),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_active_set (rsp_active_set),
      .rsp_accepted   (rsp_accepted),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mem_ctl        (mem_ctl),
      .mem_rd_addr    (mem_rd_addr),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_data    (mem_rd_data)
   );

   // Transition table, one row of next-state masks per symbol.
   nfa_wa_table #(
      .DEPTH (NUM_SYMBOLS),
      .WIDTH (ROWW)
   ) u_table (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // A row is never read and written in the same cycle.
   `NFA_ASSERT_NEVER(a_no_rd_wr_overlap, clock, reset, mem_ctl.rd_en && mem_ctl.wr_en)
   // No table write while the block can take a new item.
   `NFA_ASSERT_NEVER(a_no_write_when_open, clock, reset, !req_stall && mem_ctl.wr_en)
   // Once an item transfers, the next one waits until this one is finished.
   `NFA_ASSERT_NEXT(a_accept_interlock, clock, reset, req_valid && !req_stall, req_stall)
   // A table read happens only on the transfer of an item.
   `NFA_ASSERT_NEVER(a_read_on_transfer, clock, reset, mem_ctl.rd_en && !(req_valid && !req_stall))

endmodule

`default_nettype wire

/* src/nfa_wa_table.sv */
// Transition table memory: one row per symbol, one write and one read port.
// Read data is registered. Depends on nfa_wa_pkg for the control struct.
`default_nettype none

module nfa_wa_table #(
   parameter int DEPTH = nfa_wa_pkg::DEF_NUM_SYMBOLS,
   parameter int WIDTH = nfa_wa_pkg::DEF_NUM_STATES * nfa_wa_pkg::DEF_NUM_STATES
) (
   input  wire                         clock,
   input  wire nfa_wa_pkg::mem_ctl_type ctl,
   input  wire [$clog2(DEPTH)-1:0]     rd_addr,
   input  wire [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire [WIDTH-1:0]             wr_data,
   output logic [WIDTH-1:0]            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds between reads.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/nfa_wa_core.sv */
// Sequencer of the NFA word acceptance unit: table clearing, item decode,
// read-modify-write of table rows, active set update and result register.
// Depends on nfa_wa_pkg.
`default_nettype none

module nfa_wa_core #(
   parameter int NUM_STATES  = nfa_wa_pkg::DEF_NUM_STATES,
   parameter int NUM_SYMBOLS = nfa_wa_pkg::DEF_NUM_SYMBOLS
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // Request channel.
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire [nfa_wa_pkg::OPCODE_W-1:0]       req_opcode,
   input  wire [nfa_wa_pkg::STATE_W-1:0]        req_from_state,
   input  wire [nfa_wa_pkg::SYMBOL_W-1:0]       req_symbol,
   input  wire [nfa_wa_pkg::STATE_W-1:0]        req_to_state,
   // Response channel.
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [nfa_wa_pkg::SET_W-1:0]         rsp_active_set,
   output logic                                 rsp_accepted,
   // Configuration write channel.
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [nfa_wa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [nfa_wa_pkg::SET_W-1:0]          csr_wdata,
   // Table memory.
   output nfa_wa_pkg::mem_ctl_type              mem_ctl,
   output logic [$clog2(NUM_SYMBOLS)-1:0]       mem_rd_addr,
   output logic [$clog2(NUM_SYMBOLS)-1:0]       mem_wr_addr,
   output logic [NUM_STATES*NUM_STATES-1:0]     mem_wr_data,
   input  wire [NUM_STATES*NUM_STATES-1:0]      mem_rd_data
);

   localparam int SAW   = $clog2(NUM_SYMBOLS);
   localparam int ROWW  = NUM_STATES * NUM_STATES;
   localparam int BIW   = $clog2(ROWW);
   localparam int EXT_W = (NUM_STATES > nfa_wa_pkg::SET_W) ? NUM_STATES : nfa_wa_pkg::SET_W;

   nfa_wa_pkg::state_type state_ff, state_in;

   logic [SAW-1:0]                       clr_cnt_ff, clr_cnt_in;
   logic [nfa_wa_pkg::OPCODE_W-1:0]      op_ff, op_in;
   logic                                 add_ok_ff, add_ok_in;
   logic                                 sym_ok_ff, sym_ok_in;
   logic [SAW-1:0]                       sym_addr_ff, sym_addr_in;
   logic [BIW-1:0]                       bit_idx_ff, bit_idx_in;
   logic [NUM_STATES-1:0]                cur_set_ff, cur_set_in;
   logic [nfa_wa_pkg::STATE_W-1:0]       init_state_ff, init_state_in;
   logic [nfa_wa_pkg::SET_W-1:0]         final_mask_ff, final_mask_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [nfa_wa_pkg::SET_W-1:0]         rsp_set_ff, rsp_set_in;
   logic                                 rsp_acc_ff, rsp_acc_in;

   logic                                 take;
   logic                                 slot_free;
   logic                                 rsp_load;
   logic                                 req_sym_ok;
   logic [NUM_STATES-1:0]                begin_set;
   logic [NUM_STATES-1:0]                merged;
   logic [EXT_W-1:0]                     cur_ext;

   assign req_stall = (state_ff != nfa_wa_pkg::ST_IDLE);
   assign take      = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign req_sym_ok = (int'(req_symbol) < NUM_SYMBOLS);

   // Start set: one-hot on the start state, empty when it is out of range.
   assign begin_set = (int'(init_state_ff) < NUM_STATES)
                      ? (NUM_STATES'(1) << init_state_ff) : '0;

   // Union of the masks of all active states; row bit s*N+t is s -> t.
   always_comb begin
      merged = '0;
      for (int t = 0; t < NUM_STATES; t++) begin
         for (int s = 0; s < NUM_STATES; s++) begin
            merged[t] = merged[t] | (cur_set_ff[s] & mem_rd_data[s*NUM_STATES + t]);
         end
      end
   end

   // Result view of the active set, padded or cut to the port width.
   assign cur_ext = EXT_W'(cur_set_ff);

   // Sequencer and table access.
   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      op_in       = op_ff;
      add_ok_in   = add_ok_ff;
      sym_ok_in   = sym_ok_ff;
      sym_addr_in = sym_addr_ff;
      bit_idx_in  = bit_idx_ff;
      cur_set_in  = cur_set_ff;
      rsp_load    = 1'b0;
      mem_ctl     = '0;
      mem_rd_addr = req_symbol[SAW-1:0];
      mem_wr_addr = sym_addr_ff;
      mem_wr_data = mem_rd_data | (ROWW'(1) << bit_idx_ff);

      case (state_ff)
         nfa_wa_pkg::ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = clr_cnt_ff;
            mem_wr_data   = '0;
            clr_cnt_in    = clr_cnt_ff + SAW'(1);
            if (clr_cnt_ff == SAW'(NUM_SYMBOLS - 1)) begin
               state_in = nfa_wa_pkg::ST_IDLE;
            end
         end
         nfa_wa_pkg::ST_IDLE: begin
            if (take) begin
               op_in       = req_opcode;
               sym_ok_in   = req_sym_ok;
               sym_addr_in = req_symbol[SAW-1:0];
               add_ok_in   = req_sym_ok && (int'(req_from_state) < NUM_STATES) &&
                             (int'(req_to_state) < NUM_STATES);
               bit_idx_in  = BIW'(int'(req_from_state) * NUM_STATES + int'(req_to_state));
               case (req_opcode)
                  nfa_wa_pkg::OP_ADD, nfa_wa_pkg::OP_CONSUME: begin
                     mem_ctl.rd_en = 1'b1;
                     state_in      = nfa_wa_pkg::ST_EXEC;
                  end
                  nfa_wa_pkg::OP_BEGIN: begin
                     cur_set_in = begin_set;
                     state_in   = nfa_wa_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = nfa_wa_pkg::ST_DONE;
                  end
               endcase
            end
         end
         nfa_wa_pkg::ST_EXEC: begin
            // Row read data is valid now: set one bit, or merge the masks.
            if (op_ff == nfa_wa_pkg::OP_ADD) begin
               mem_ctl.wr_en = add_ok_ff;
            end else begin
               cur_set_in = sym_ok_ff ? merged : '0;
            end
            state_in = nfa_wa_pkg::ST_DONE;
         end
         nfa_wa_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = nfa_wa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nfa_wa_pkg::ST_IDLE;
         end
      endcase
   end

   // Configuration registers.
   always_comb begin
      init_state_in = init_state_ff;
      final_mask_in = final_mask_ff;
      if (csr_valid) begin
         case (csr_index)
            nfa_wa_pkg::CSR_INITIAL_STATE: begin
               init_state_in = csr_wdata[nfa_wa_pkg::STATE_W-1:0];
            end
            nfa_wa_pkg::CSR_FINAL_MASK: begin
               final_mask_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Result register: loaded when the item is done and the slot is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_set_in   = rsp_set_ff;
      rsp_acc_in   = rsp_acc_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_set_in   = cur_ext[nfa_wa_pkg::SET_W-1:0];
         rsp_acc_in   = |(cur_ext[nfa_wa_pkg::SET_W-1:0] & final_mask_ff);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nfa_wa_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         cur_set_ff    <= '0;
         init_state_ff <= '0;
         final_mask_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         cur_set_ff    <= cur_set_in;
         init_state_ff <= init_state_in;
         final_mask_ff <= final_mask_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      add_ok_ff   <= add_ok_in;
      sym_ok_ff   <= sym_ok_in;
      sym_addr_ff <= sym_addr_in;
      bit_idx_ff  <= bit_idx_in;
      rsp_set_ff  <= rsp_set_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_active_set = rsp_set_ff;
   assign rsp_accepted   = rsp_acc_ff;

endmodule

`default_nettype wire

/* test/tb_nfa_word_acceptance_unit.sv */
// Testbench of the NFA word acceptance unit: directed rows, then random automata and words.
// Results are checked against a predictor kept inside this file; needs only nfa_wa_pkg and the RTL.
`timescale 1ns / 100ps

module tb_nfa_word_acceptance_unit;

   localparam int NUM_STATES  = nfa_wa_pkg::DEF_NUM_STATES;
   localparam int NUM_SYMBOLS = nfa_wa_pkg::DEF_NUM_SYMBOLS;
   localparam logic [nfa_wa_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE       = 4;
   localparam int PHASE_ITEMS  = 175;
   localparam int DIR_ROWS     = 23;
   localparam int DIR_SPLIT    = 15;
   localparam int ALPHABET_LEN = 4;

   // One result as the block returns it.
   typedef struct packed {
      logic [nfa_wa_pkg::SET_W-1:0] active_set;
      logic                         accepted;
   } nfa_result_type;

   // One input item, optionally with its result written out by hand.
   typedef struct packed {
      logic [nfa_wa_pkg::OPCODE_W-1:0] opcode;
      logic [nfa_wa_pkg::STATE_W-1:0]  from_state;
      logic [nfa_wa_pkg::SYMBOL_W-1:0] symbol;
      logic [nfa_wa_pkg::STATE_W-1:0]  to_state;
      logic                            has_result;
      logic [nfa_wa_pkg::SET_W-1:0]    active_set;
      logic                            accepted;
   } nfa_item_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [nfa_wa_pkg::OPCODE_W-1:0]      req_opcode = '0;
   logic [nfa_wa_pkg::STATE_W-1:0]       req_from_state = '0;
   logic [nfa_wa_pkg::SYMBOL_W-1:0]      req_symbol = '0;
   logic [nfa_wa_pkg::STATE_W-1:0]       req_to_state = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [nfa_wa_pkg::SET_W-1:0]         rsp_active_set;
   logic                                 rsp_accepted;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [nfa_wa_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [nfa_wa_pkg::SET_W-1:0]         csr_wdata = '0;

   // Hand-typed expectation that travels with the item on the request port.
   logic                                 item_has_result = 1'b0;
   nfa_result_type                       item_result = '0;

   // Predictor state: transition masks, active set and register copies.
   logic [nfa_wa_pkg::SET_W-1:0]         next_set_table [NUM_STATES][NUM_SYMBOLS];
   logic [nfa_wa_pkg::SET_W-1:0]         active_states = '0;
   logic [nfa_wa_pkg::STATE_W-1:0]       start_state = '0;
   logic [nfa_wa_pkg::SET_W-1:0]         accept_mask = '0;

   nfa_result_type                       awaited_results [$];
   int                                   fail_count = 0;
   int                                   cycle_count = 0;
   int                                   burst_left = 0;
   bit                                   gaps_on = 1'b1;
   int                                   holds_asked = 0;

   nfa_word_acceptance_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_from_state (req_from_state),
      .req_symbol     (req_symbol),
      .req_to_state   (req_to_state),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_active_set (rsp_active_set),
      .rsp_accepted   (rsp_accepted),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Steps the automaton by one item and returns the result it produces.
   function automatic nfa_result_type step_automaton(input nfa_item_type item);
      logic [nfa_wa_pkg::SET_W-1:0] merged;
      nfa_result_type               res;
      merged = '0;
      case (item.opcode)
         nfa_wa_pkg::OP_ADD: begin
            if (int'(item.from_state) < NUM_STATES && int'(item.to_state) < NUM_STATES &&
                int'(item.symbol) < NUM_SYMBOLS) begin
               next_set_table[item.from_state][item.symbol][item.to_state] = 1'b1;
            end
         end
         nfa_wa_pkg::OP_BEGIN: begin
            if (int'(start_state) < NUM_STATES) begin
               active_states = '0;
               active_states[start_state] = 1'b1;
            end else begin
               active_states = '0;
            end
         end
         nfa_wa_pkg::OP_CONSUME: begin
            if (int'(item.symbol) < NUM_SYMBOLS) begin
               for (int s = 0; s < NUM_STATES; s++) begin
                  if (active_states[s]) begin
                     merged = merged | next_set_table[s][item.symbol];
                  end
               end
            end
            active_states = merged;
         end
         default: begin
         end
      endcase
      res.active_set = active_states;
      res.accepted   = |(active_states & accept_mask);
      return res;
   endfunction

   // Watches all three ports at the rising edge: checks results, predicts accepted items
   // and follows register writes.
   always @(posedge clock) begin : port_monitor
      nfa_result_type seen;
      nfa_result_type wanted;
      nfa_item_type   taken;
      if (reset) begin
         for (int s = 0; s < NUM_STATES; s++) begin
            for (int y = 0; y < NUM_SYMBOLS; y++) begin
               next_set_table[s][y] = '0;
            end
         end
         active_states = '0;
         start_state   = '0;
         accept_mask   = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.active_set = rsp_active_set;
            seen.accepted   = rsp_accepted;
            if (awaited_results.size() == 0) begin
               $error("unexpected result: active_set %h accepted %b", seen.active_set,
                      seen.accepted);
               fail_count++;
            end else begin
               wanted = awaited_results.pop_front();
               if (seen.active_set !== wanted.active_set) begin
                  $error("active_set: expected %h, got %h", wanted.active_set,
                         seen.active_set);
                  fail_count++;
               end
               if (seen.accepted !== wanted.accepted) begin
                  $error("accepted: expected %b, got %b", wanted.accepted, seen.accepted);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            taken = '0;
            taken.opcode     = req_opcode;
            taken.from_state = req_from_state;
            taken.symbol     = req_symbol;
            taken.to_state   = req_to_state;
            wanted = step_automaton(taken);
            if (item_has_result) begin
               wanted = item_result;
            end
            awaited_results.insert(awaited_results.size(), wanted);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               nfa_wa_pkg::CSR_INITIAL_STATE:
                  start_state = csr_wdata[nfa_wa_pkg::STATE_W-1:0];
               nfa_wa_pkg::CSR_FINAL_MASK:
                  accept_mask = csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Receiver: a changing stall pattern, plus a long hold-off whenever one is asked for.
   initial begin : receiver
      int pattern;
      int pattern_left;
      int hold_left;
      int holds_taken;
      pattern = 0;
      pattern_left = 0;
      hold_left = 0;
      holds_taken = 0;
      forever begin
         @(negedge clock);
         if (holds_taken != holds_asked) begin
            holds_taken = holds_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            if (pattern_left == 0) begin
               pattern = $urandom_range(0, 3);
               pattern_left = $urandom_range(20, 120);
            end
            pattern_left--;
            case (pattern)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 2) == 0);
               2: rsp_stall = ~rsp_stall;
               default: rsp_stall = ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   function automatic nfa_item_type make_item(input logic [nfa_wa_pkg::OPCODE_W-1:0] op,
                                              input logic [nfa_wa_pkg::STATE_W-1:0] from,
                                              input logic [nfa_wa_pkg::SYMBOL_W-1:0] sym,
                                              input logic [nfa_wa_pkg::STATE_W-1:0] to);
      nfa_item_type item;
      item = '0;
      item.opcode     = op;
      item.from_state = from;
      item.symbol     = sym;
      item.to_state   = to;
      return item;
   endfunction

   // Offers one item, waits for its transfer; with gaps on, the sender idles between random bursts.
   task automatic send_item(input nfa_item_type item);
      @(negedge clock);
      if (gaps_on && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_valid       = 1'b1;
      req_opcode      = item.opcode;
      req_from_state  = item.from_state;
      req_symbol      = item.symbol;
      req_to_state    = item.to_state;
      item_has_result = item.has_result;
      item_result.active_set = item.active_set;
      item_result.accepted   = item.accepted;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   // Stops sending and waits until every expected result has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes both registers while the block is idle.
   task automatic configure(input logic [nfa_wa_pkg::SET_W-1:0] start_word,
                            input logic [nfa_wa_pkg::SET_W-1:0] mask);
      drain_results();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = nfa_wa_pkg::CSR_INITIAL_STATE;
      csr_wdata = start_word;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index = nfa_wa_pkg::CSR_FINAL_MASK;
      csr_wdata = mask;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [nfa_wa_pkg::STATE_W-1:0] any_state();
      return nfa_wa_pkg::STATE_W'($urandom_range(0, NUM_STATES - 1));
   endfunction

   function automatic logic [nfa_wa_pkg::SYMBOL_W-1:0] any_symbol();
      return nfa_wa_pkg::SYMBOL_W'($urandom_range(0, 255));
   endfunction

   // Builds a random automaton over a small alphabet, then runs words through it,
   // with some noise items and broken words mixed in.
   task automatic run_random_phase(input bit with_gaps, input bit with_hold);
      logic [nfa_wa_pkg::SYMBOL_W-1:0] alphabet [ALPHABET_LEN];
      int sent;
      int word_len;
      int pick;
      bit held;
      sent = 0;
      held = 1'b0;
      gaps_on = with_gaps;
      for (int k = 0; k < ALPHABET_LEN; k++) begin
         alphabet[k] = any_symbol();
      end
      // Extreme symbols join the alphabet now and then.
      if ($urandom_range(0, 1) == 0) alphabet[0] = 8'h00;
      if ($urandom_range(0, 1) == 0) alphabet[1] = 8'hFF;

      repeat (48) begin
         send_item(make_item(nfa_wa_pkg::OP_ADD, any_state(),
                             alphabet[$urandom_range(0, ALPHABET_LEN - 1)], any_state()));
         sent++;
      end
      while (sent < PHASE_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            send_item(make_item(nfa_wa_pkg::OPCODE_W'($urandom_range(0, 3)), any_state(),
                                any_symbol(), any_state()));
            sent++;
         end else if (pick == 1) begin
            send_item(make_item(nfa_wa_pkg::OP_CONSUME, any_state(), any_symbol(),
                                any_state()));
            sent++;
         end else begin
            send_item(make_item(nfa_wa_pkg::OP_BEGIN, any_state(), any_symbol(),
                                any_state()));
            sent++;
            word_len = $urandom_range(1, 10);
            for (int k = 0; k < word_len; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_item(make_item(nfa_wa_pkg::OP_CONSUME, any_state(), any_symbol(),
                                      any_state()));
               end else begin
                  send_item(make_item(nfa_wa_pkg::OP_CONSUME, any_state(),
                                      alphabet[$urandom_range(0, ALPHABET_LEN - 1)],
                                      any_state()));
               end
               sent++;
            end
         end
         // Long receiver hold-off while items keep coming, so the block backs up.
         if (with_hold && !held && sent > PHASE_ITEMS / 2) begin
            holds_asked++;
            held = 1'b1;
         end
      end
   endtask

   // Directed rows; rows with has_result set carry their result typed in.
   nfa_item_type directed_rows [DIR_ROWS] = '{
      // Reset registers: start state 0, nothing accepting.
      '{nfa_wa_pkg::OP_CONSUME, 4'd0,  8'h00, 4'd0,  1'b1, 16'h0000, 1'b0},
      '{OP_UNUSED,              4'd15, 8'hFF, 4'd15, 1'b1, 16'h0000, 1'b0},
      '{nfa_wa_pkg::OP_BEGIN,   4'd0,  8'h00, 4'd0,  1'b1, 16'h0001, 1'b0},
      '{nfa_wa_pkg::OP_ADD,     4'd0,  8'hFF, 4'd15, 1'b1, 16'h0001, 1'b0},
      '{nfa_wa_pkg::OP_ADD,     4'd0,  8'hFF, 4'd15, 1'b1, 16'h0001, 1'b0},
      '{nfa_wa_pkg::OP_ADD,     4'd0,  8'hFF, 4'd0,  1'b1, 16'h0001, 1'b0},
      '{nfa_wa_pkg::OP_ADD,     4'd15, 8'h00, 4'd15, 1'b1, 16'h0001, 1'b0},
      '{nfa_wa_pkg::OP_ADD,     4'd15, 8'h00, 4'd1,  1'b1, 16'h0001, 1'b0},
      '{nfa_wa_pkg::OP_ADD,     4'd1,  8'h00, 4'd0,  1'b1, 16'h0001, 1'b0},
      '{nfa_wa_pkg::OP_CONSUME, 4'd0,  8'hFF, 4'd0,  1'b1, 16'h8001, 1'b0},
      '{nfa_wa_pkg::OP_CONSUME, 4'd15, 8'h00, 4'd15, 1'b0, 16'h0000, 1'b0},
      '{nfa_wa_pkg::OP_CONSUME, 4'd0,  8'h00, 4'd0,  1'b0, 16'h0000, 1'b0},
      '{nfa_wa_pkg::OP_CONSUME, 4'd0,  8'h80, 4'd0,  1'b1, 16'h0000, 1'b0},
      '{OP_UNUSED,              4'd0,  8'h00, 4'd0,  1'b1, 16'h0000, 1'b0},
      '{nfa_wa_pkg::OP_BEGIN,   4'd15, 8'hFF, 4'd15, 1'b1, 16'h0001, 1'b0},
      // Start state 15, every state accepting.
      '{nfa_wa_pkg::OP_BEGIN,   4'd0,  8'h00, 4'd0,  1'b1, 16'h8000, 1'b1},
      '{nfa_wa_pkg::OP_CONSUME, 4'd0,  8'h00, 4'd0,  1'b0, 16'h0000, 1'b0},
      '{OP_UNUSED,              4'd0,  8'h00, 4'd0,  1'b0, 16'h0000, 1'b0},
      '{nfa_wa_pkg::OP_CONSUME, 4'd0,  8'h01, 4'd0,  1'b1, 16'h0000, 1'b0},
      '{nfa_wa_pkg::OP_CONSUME, 4'd0,  8'h00, 4'd0,  1'b1, 16'h0000, 1'b0},
      '{nfa_wa_pkg::OP_ADD,     4'd15, 8'hFF, 4'd15, 1'b1, 16'h0000, 1'b0},
      '{nfa_wa_pkg::OP_BEGIN,   4'd0,  8'h00, 4'd0,  1'b1, 16'h8000, 1'b1},
      '{nfa_wa_pkg::OP_CONSUME, 4'd0,  8'hFF, 4'd0,  1'b0, 16'h0000, 1'b0}
   };

   // Ends the run if it hangs.
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   // Main sequence: reset, directed rows, random phases under several register settings.
   initial begin : stimulus
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (r == DIR_SPLIT) begin
            configure(16'd15, 16'hFFFF);
         end
         send_item(directed_rows[r]);
      end

      configure(16'd0, 16'h0000);
      run_random_phase(1'b1, 1'b0);
      configure(16'd15, 16'hFFFF);
      run_random_phase(1'b1, 1'b1);
      configure(nfa_wa_pkg::SET_W'($urandom_range(0, NUM_STATES - 1)),
                nfa_wa_pkg::SET_W'($urandom_range(0, 65535)));
      run_random_phase(1'b0, 1'b0);
      // Upper data bits of the start-state write are don't-care.
      configure(nfa_wa_pkg::SET_W'($urandom_range(0, 65535)),
                nfa_wa_pkg::SET_W'($urandom_range(0, 65535)));
      run_random_phase(1'b1, 1'b0);
      configure(16'd0, 16'h8000);
      run_random_phase(1'b1, 1'b1);
      configure(nfa_wa_pkg::SET_W'($urandom_range(0, NUM_STATES - 1)),
                nfa_wa_pkg::SET_W'($urandom_range(0, 65535)));
      run_random_phase(1'b0, 1'b0);

      drain_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
